// ===== hw/rtl/bitmap_first_fit_allocator_assert.svh =====
// Assertion macros for the bitmap first-fit allocator.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BFFA_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
        else $error("bffa assertion failed");

// Next-cycle implication, disabled during reset.
`define BFFA_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
        else $error("bffa assertion failed");

`endif

// ===== hw/rtl/bffa_pkg.sv =====
// Shared types and constants of the bitmap first-fit allocator.
`default_nettype none
package bffa_pkg;

    localparam int MAP_BITS_DEF = 1024;
    localparam int CFG_W        = 11;
    localparam int WORD_W       = 32;
    localparam int SEL_W        = 5;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_ALLOC = 2'd3;

    typedef enum logic [3:0] {
        S_INIT_START,
        S_INIT_RUN,
        S_IDLE,
        S_DECODE,
        S_BIT_OP,
        S_CLR_RUN,
        S_SCAN,
        S_DONE
    } state_t;

    typedef enum logic [0:0] {
        ADDR_HOLD,
        ADDR_INC
    } addr_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_BIT,
        WR_ALLOC,
        WR_CLEAR,
        WR_INIT
    } wr_op_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_RANGE,
        RES_EMPTY,
        RES_READ,
        RES_ALLOC
    } res_op_t;

    typedef struct packed {
        logic     accept;
        addr_op_t addr_op;
        wr_op_t   wr_op;
        res_op_t  res_op;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       idx_oor;
        logic       size_zero;
        logic       size_le1;
        logic       hit;
        logic       at_map_end;
        logic       at_clr_end;
        logic       at_scan_end;
        logic       out_free;
    } status_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bffa_ctrl.sv =====
// Controller state machine of the bitmap first-fit allocator.
`default_nettype none
module bffa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire bffa_pkg::status_t sts,
    output bffa_pkg::cmd_t         cmd
);
    import bffa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_START;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT_START: state_next = S_INIT_RUN;
            S_INIT_RUN:
            begin
                if (sts.at_map_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.mode)
                    MODE_READ, MODE_WRITE:
                        state_next = sts.idx_oor ? S_DONE : S_BIT_OP;
                    MODE_CLEAR:
                        state_next = sts.size_zero ? S_DONE : S_CLR_RUN;
                    default:
                        state_next = sts.size_le1 ? S_DONE : S_SCAN;
                endcase
            end
            S_BIT_OP: state_next = S_DONE;
            S_CLR_RUN:
            begin
                if (sts.at_clr_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (sts.hit || sts.at_scan_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT_START;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.addr_op  = ADDR_HOLD;
        cmd.wr_op    = WR_NONE;
        cmd.res_op   = RES_NONE;
        in_stall     = 1'b1;
        case (state_reg)
            S_INIT_START: cmd.addr_op = ADDR_INC;
            S_INIT_RUN:
            begin
                cmd.addr_op = ADDR_INC;
                cmd.wr_op   = WR_INIT;
            end
            S_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            S_DECODE:
            begin
                case (sts.mode)
                    MODE_READ, MODE_WRITE:
                    begin
                        if (sts.idx_oor)
                        begin
                            cmd.res_op = RES_RANGE;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        if (sts.size_zero)
                        begin
                            cmd.res_op = RES_EMPTY;
                        end
                        else
                        begin
                            cmd.addr_op = ADDR_INC;
                        end
                    end
                    default:
                    begin
                        if (sts.size_le1)
                        begin
                            cmd.res_op = RES_EMPTY;
                        end
                        else
                        begin
                            cmd.addr_op = ADDR_INC;
                        end
                    end
                endcase
            end
            S_BIT_OP:
            begin
                if (sts.mode == MODE_READ)
                begin
                    cmd.res_op = RES_READ;
                end
                else
                begin
                    cmd.wr_op  = WR_BIT;
                    cmd.res_op = RES_OK;
                end
            end
            S_CLR_RUN:
            begin
                cmd.wr_op   = WR_CLEAR;
                cmd.addr_op = ADDR_INC;
                if (sts.at_clr_end)
                begin
                    cmd.res_op = RES_OK;
                end
            end
            S_SCAN:
            begin
                if (sts.hit)
                begin
                    cmd.wr_op  = WR_ALLOC;
                    cmd.res_op = RES_ALLOC;
                end
                else if (sts.at_scan_end)
                begin
                    cmd.res_op = RES_EMPTY;
                end
                else
                begin
                    cmd.addr_op = ADDR_INC;
                end
            end
            S_DONE: cmd.out_load = sts.out_free;
            default: cmd.addr_op = ADDR_HOLD;
        endcase
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bffa_datapath.sv =====
// Datapath of the bitmap first-fit allocator: map memory, scan logic, result and output registers.
`default_nettype none
module bffa_datapath #(
    parameter int MAP_BITS = bffa_pkg::MAP_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire bffa_pkg::cmd_t            cmd,
    output bffa_pkg::status_t              sts,
    input  wire logic                      cfg_write_en,
    input  wire logic [bffa_pkg::CFG_W-1:0] cfg_write_data,
    input  wire logic [1:0]                mode,
    input  wire logic [9:0]                index,
    input  wire logic                      write_value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     status,
    output logic                           slot_bit,
    output logic [9:0]                     alloc_index
);
    import bffa_pkg::*;

    localparam int WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    logic [WORD_W-1:0] mem [WORDS];

    logic [CFG_W-1:0]  nbits_reg;
    logic [1:0]        mode_reg;
    logic [9:0]        idx_reg;
    logic              wval_reg;
    logic [AW-1:0]     addr_reg;
    logic [AW-1:0]     addr_next;
    logic [AW-1:0]     chk_addr_reg;
    logic [WORD_W-1:0] rd_data_reg;

    logic [1:0]        res_status_reg;
    logic              res_bit_reg;
    logic [9:0]        res_alloc_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        out_status_reg;
    logic              out_bit_reg;
    logic [9:0]        out_alloc_reg;

    logic [CFG_W-1:0]  size;
    logic [CFG_W:0]    round8;
    logic [CFG_W:0]    limit;
    logic [AW-1:0]     clr_end;
    logic [AW-1:0]     scan_end;
    logic [WORD_W-1:0] cand;
    logic [WORD_W-1:0] keep;
    logic [SEL_W-1:0]  hit_pos;
    logic [WORD_W-1:0] wr_data;
    logic [31:0]       word_base;

    // managed size and clear extent
    always_comb
    begin
        size     = (32'(nbits_reg) > 32'(MAP_BITS)) ? CFG_W'(MAP_BITS) : nbits_reg;
        round8   = ({1'b0, size} + (CFG_W+1)'(7)) & ~((CFG_W+1)'(7));
        limit    = (32'(round8) > 32'(MAP_BITS)) ? (CFG_W+1)'(MAP_BITS) : round8;
        clr_end  = AW'((32'(limit) - 32'd1) >> SEL_W);
        scan_end = AW'((32'(size) - 32'd1) >> SEL_W);
    end

    // free-slot candidates and clear mask of the word under check
    always_comb
    begin
        logic [31:0] slot;
        word_base = 32'(chk_addr_reg) << SEL_W;
        cand      = '0;
        keep      = '0;
        hit_pos   = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            slot    = word_base + 32'(j);
            cand[j] = !rd_data_reg[j] && (slot >= 32'd1) && (slot < 32'(size));
            keep[j] = slot >= 32'(limit);
        end
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (cand[j])
            begin
                hit_pos = SEL_W'(j);
            end
        end
    end

    always_comb
    begin
        wr_data = rd_data_reg;
        case (cmd.wr_op)
            WR_BIT:   wr_data[idx_reg[SEL_W-1:0]] = wval_reg;
            WR_ALLOC: wr_data[hit_pos] = 1'b1;
            WR_CLEAR: wr_data = rd_data_reg & keep;
            WR_INIT:  wr_data = '0;
            default:  wr_data = rd_data_reg;
        endcase
    end

    always_comb
    begin
        if (cmd.accept)
        begin
            addr_next = (mode == MODE_READ || mode == MODE_WRITE)
                      ? AW'(index >> SEL_W) : '0;
        end
        else if (cmd.addr_op == ADDR_INC && addr_reg != LAST_WORD)
        begin
            addr_next = addr_reg + AW'(1);
        end
        else
        begin
            addr_next = addr_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbits_reg     <= CFG_RESET;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                nbits_reg <= cfg_write_data;
            end
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // map memory: one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[addr_reg];
        chk_addr_reg <= addr_reg;
        if (cmd.wr_op != WR_NONE)
        begin
            mem[chk_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mode_reg <= mode;
            idx_reg  <= index;
            wval_reg <= write_value;
        end
        case (cmd.res_op)
            RES_OK:
            begin
                res_status_reg <= ST_OK;
                res_bit_reg    <= 1'b0;
                res_alloc_reg  <= '0;
            end
            RES_RANGE:
            begin
                res_status_reg <= ST_RANGE;
                res_bit_reg    <= 1'b0;
                res_alloc_reg  <= '0;
            end
            RES_EMPTY:
            begin
                res_status_reg <= ST_EMPTY;
                res_bit_reg    <= 1'b0;
                res_alloc_reg  <= '0;
            end
            RES_READ:
            begin
                res_status_reg <= ST_OK;
                res_bit_reg    <= rd_data_reg[idx_reg[SEL_W-1:0]];
                res_alloc_reg  <= '0;
            end
            RES_ALLOC:
            begin
                res_status_reg <= ST_OK;
                res_bit_reg    <= 1'b0;
                res_alloc_reg  <= 10'(word_base + 32'(hit_pos));
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_bit_reg    <= res_bit_reg;
            out_alloc_reg  <= res_alloc_reg;
        end
    end

    always_comb
    begin
        sts.mode        = mode_reg;
        sts.idx_oor     = {1'b0, idx_reg} >= size;
        sts.size_zero   = size == '0;
        sts.size_le1    = size <= CFG_W'(1);
        sts.hit         = |cand;
        sts.at_map_end  = chk_addr_reg == LAST_WORD;
        sts.at_clr_end  = chk_addr_reg == clr_end;
        sts.at_scan_end = chk_addr_reg == scan_end;
        sts.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign slot_bit    = out_bit_reg;
    assign alloc_index = out_alloc_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_first_fit_allocator.sv =====
// Top level of the bitmap first-fit allocator: controller, datapath and checks.
`default_nettype none
// Bitmap slot allocator over MAP_BITS one-bit slots (1 used, 0 free) kept in
// a 32-bit-wide map RAM. Each input beat carries a mode: read one slot, write
// one slot, clear the managed map, or allocate the lowest free slot from 1 up
// to size-1, where size is nbits_in_use limited to MAP_BITS. Every input beat
// yields exactly one output beat. alloc_index 0 means nothing was handed out.
// Clear zeroes the map up to limit, which is size rounded up to 8 and capped
// at MAP_BITS; allocate scans words from 0 and stops at the first word with a
// free slot or at the word holding slot size-1. The block is ready for the
// next beat in the cycle after the result is loaded. Allocate and clear are
// paced by the RAM read port: one 32-bit word is handled per cycle, through a
// priority encoder when allocating, with the read of the next word overlapped.
// One beat is in flight at a time; a finished result waits in the output
// register, so the next beat can be accepted and worked on while the previous
// result is held by out_stall. After reset the block zeroes the map, one word
// a cycle, with in_stall high; the configuration register may be written
// during that time.
module bitmap_first_fit_allocator #(
    parameter int MAP_BITS = bffa_pkg::MAP_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write_en,
    input  wire logic [bffa_pkg::CFG_W-1:0] cfg_write_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 mode,
    input  wire logic [9:0]                 index,
    input  wire logic                       write_value,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      status,
    output logic                            slot_bit,
    output logic [9:0]                      alloc_index
);
    import bffa_pkg::*;

    cmd_t    cmd;
    status_t sts;

    bffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    bffa_datapath #(
        .MAP_BITS (MAP_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .mode           (mode),
        .index          (index),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot_bit       (slot_bit),
        .alloc_index    (alloc_index)
    );

`include "bitmap_first_fit_allocator_assert.svh"

    // an accepted beat keeps the input side busy in the next cycle
    `BFFA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

    // a result is loaded only when the output register is free
    `BFFA_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.out_load, sts.out_free)

    // the map is only written while the block is busy
    `BFFA_ASSERT_NOW(a_write_when_busy, clk, rst_n, cmd.wr_op != WR_NONE, in_stall)

    // an error beat carries zero in both data fields
    `BFFA_ASSERT_NOW(a_error_fields_zero, clk, rst_n, out_valid && status != ST_OK,
        slot_bit == 1'b0 && alloc_index == 10'd0)

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the bitmap first-fit slot allocator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bffa_pkg::*;

    localparam int MAP_SLOTS   = MAP_BITS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_BEATS = 119;
    localparam int HOLD_CYCLES = 600;

    // One request beat and one result beat, at the port widths.
    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] index;
        logic       write_value;
    } slot_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       slot_bit;
        logic [9:0] alloc_index;
    } slot_resp_t;

    // Clock, reset and block inputs; every input starts at a known value.
    logic               clk            = 1'b0;
    logic               rst_n          = 1'b0;
    logic               cfg_write_en   = 1'b0;
    logic [CFG_W-1:0]   cfg_write_data = '0;
    logic               in_valid       = 1'b0;
    logic [1:0]         mode           = MODE_READ;
    logic [9:0]         index          = '0;
    logic               write_value    = 1'b0;
    logic               out_stall      = 1'b0;

    logic               in_stall;
    logic               out_valid;
    logic [1:0]         status;
    logic               slot_bit;
    logic [9:0]         alloc_index;

    // Pending request beats (filled by the stimulus block, drained by the
    // driver) and the results the slot map owes us, oldest first.
    slot_req_t          req_q[$];
    slot_resp_t         owed_q[$];

    // Our own copy of the slot map and the size register.
    logic [MAP_SLOTS-1:0] slot_map = '0;
    logic [CFG_W-1:0]     size_reg = CFG_RESET;

    // Idle and stall rates in percent, changed only between phases.
    int                 send_idle_pct = 0;
    int                 stall_pct     = 0;

    // Long receiver hold-off, kicked once by the stimulus block.
    logic               hold_kick = 1'b0;
    int                 hold_left = 0;

    int                 bad_beats = 0;
    int                 cycle_cnt = 0;

    bitmap_first_fit_allocator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .index          (index),
        .write_value    (write_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .slot_bit       (slot_bit),
        .alloc_index    (alloc_index)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the local slot map and returns the result the
    // block must produce for it.
    function automatic slot_resp_t apply_slot_req(input slot_req_t req);
        slot_resp_t  resp;
        int unsigned span;
        int unsigned clr_end;
        resp.status      = ST_OK;
        resp.slot_bit    = 1'b0;
        resp.alloc_index = '0;
        // Sizes above the map depth behave as the full map.
        span = (size_reg > MAP_SLOTS) ? MAP_SLOTS : size_reg;
        case (req.mode)
            MODE_READ:
            begin
                if (req.index >= span)
                    resp.status = ST_RANGE;
                else
                    resp.slot_bit = slot_map[req.index];
            end
            MODE_WRITE:
            begin
                if (req.index >= span)
                    resp.status = ST_RANGE;
                else
                    slot_map[req.index] = req.write_value;
            end
            MODE_CLEAR:
            begin
                if (span == 0)
                    resp.status = ST_EMPTY;
                else
                begin
                    // Clear runs to the next multiple of 8, capped at the map end.
                    clr_end = ((span + 7) / 8) * 8;
                    if (clr_end > MAP_SLOTS)
                        clr_end = MAP_SLOTS;
                    for (int i = 0; i < clr_end; i++)
                        slot_map[i] = 1'b0;
                end
            end
            default:
            begin
                // First fit from slot 1; slot 0 is never handed out.
                resp.status = ST_EMPTY;
                for (int i = 1; i < span; i++)
                begin
                    if (!slot_map[i])
                    begin
                        slot_map[i]      = 1'b1;
                        resp.alloc_index = i[9:0];
                        resp.status      = ST_OK;
                        break;
                    end
                end
            end
        endcase
        return resp;
    endfunction

    // Driver: predicts each accepted beat, then offers the next pending one
    // unless it rolls an idle cycle. A stalled beat is held unchanged.
    always @(posedge clk or negedge rst_n)
    begin : req_driver
        slot_req_t cur;
        slot_req_t nxt;
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            mode        <= MODE_READ;
            index       <= '0;
            write_value <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                cur.mode        = mode;
                cur.index       = index;
                cur.write_value = write_value;
                owed_q.push_back(apply_slot_req(cur));
            end
            if (!in_valid || !in_stall)
            begin
                if (req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt         = req_q.pop_front();
                    in_valid    <= 1'b1;
                    mode        <= nxt.mode;
                    index       <= nxt.index;
                    write_value <= nxt.write_value;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver hold-off counter, kept apart from the random stall.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks every accepted result beat against the oldest owed
    // result, field by field, and drives the result stall.
    always @(posedge clk or negedge rst_n)
    begin : resp_monitor
        slot_resp_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_q.size() == 0)
                begin
                    if (bad_beats < 10)
                        $display("%0t: result beat with nothing owed: %s %0d %0d %0d",
                                 $realtime, "status/bit/alloc",
                                 status, slot_bit, alloc_index);
                    bad_beats <= bad_beats + 1;
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (status !== want.status || slot_bit !== want.slot_bit ||
                        alloc_index !== want.alloc_index)
                    begin
                        if (bad_beats < 10)
                            $display({"%0t: mismatch: want status %0d bit %0d alloc %0d,",
                                      " got status %0d bit %0d alloc %0d"},
                                     $realtime, want.status, want.slot_bit,
                                     want.alloc_index, status, slot_bit, alloc_index);
                        bad_beats <= bad_beats + 1;
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic add_req(input logic [1:0] m, input logic [9:0] ix, input logic wv);
        slot_req_t req;
        req.mode        = m;
        req.index       = ix;
        req.write_value = wv;
        req_q.push_back(req);
    endtask

    // Returns on a falling edge once every beat is sent and answered.
    task automatic wait_drained();
        @(negedge clk);
        while (req_q.size() != 0 || in_valid || owed_q.size() != 0)
            @(negedge clk);
    endtask

    // Size register write; only called with nothing in flight.
    task automatic write_size(input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= val;
        size_reg = val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // One random phase: set the size, pick the idle pattern, queue beats.
    // Most beats are well formed (in-range reads and writes, allocations)
    // so the map really fills up; the rest are fully random fields.
    task automatic random_phase(input logic [CFG_W-1:0] sz, input int idle_sel,
                                input int beats, input bit long_hold);
        int unsigned span;
        int unsigned roll;
        logic [9:0]  ix;
        write_size(sz);
        span = (sz > MAP_SLOTS) ? MAP_SLOTS : sz;
        case (idle_sel)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 6; stall_pct = 6; end
        endcase
        for (int n = 0; n < beats; n++)
        begin
            roll = $urandom_range(99);
            ix   = (span == 0) ? 10'($urandom_range(1023)) : 10'($urandom_range(span - 1));
            if (roll < 10)
                add_req(2'($urandom_range(3)), 10'($urandom_range(1023)),
                        1'($urandom_range(1)));
            else if (roll < 52)
                add_req(MODE_ALLOC, 10'($urandom_range(1023)), 1'($urandom_range(1)));
            else if (roll < 75)
                add_req(MODE_WRITE, ix, 1'($urandom_range(1)));
            else if (roll < 97)
                add_req(MODE_READ, ix, 1'($urandom_range(1)));
            else
                add_req(MODE_CLEAR, 10'($urandom_range(1023)), 1'($urandom_range(1)));
        end
        // Hold the result side off while the driver keeps offering beats,
        // so the block backs up and stalls its input.
        if (long_hold)
        begin
            @(posedge clk);
            hold_kick <= 1'b1;
            @(posedge clk);
            hold_kick <= 1'b0;
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        logic [CFG_W-1:0] sizes[12];
        sizes = '{11'd33, 11'd8, 11'd2047, 11'd1, 11'd100, 11'd0,
                  11'd256, 11'd9, 11'd1024, 11'd64, 11'd2, 11'd1023};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset size (full map): map edges, slot 0, first fit,
        // reuse of a freed slot, clear.
        add_req(MODE_READ,  10'd0,    1'b0);
        add_req(MODE_READ,  10'd1023, 1'b0);
        add_req(MODE_WRITE, 10'd1023, 1'b1);
        add_req(MODE_READ,  10'd1023, 1'b0);
        add_req(MODE_WRITE, 10'd0,    1'b1);
        add_req(MODE_ALLOC, 10'd0,    1'b0);
        add_req(MODE_ALLOC, 10'd0,    1'b0);
        add_req(MODE_WRITE, 10'd2,    1'b0);
        add_req(MODE_ALLOC, 10'd0,    1'b0);
        add_req(MODE_CLEAR, 10'd0,    1'b0);
        add_req(MODE_READ,  10'd1023, 1'b0);
        add_req(MODE_ALLOC, 10'd1023, 1'b1);
        wait_drained();

        // Size zero: every index out of range, clear and alloc report empty.
        write_size(11'd0);
        add_req(MODE_READ,  10'd5, 1'b0);
        add_req(MODE_WRITE, 10'd0, 1'b1);
        add_req(MODE_CLEAR, 10'd0, 1'b0);
        add_req(MODE_ALLOC, 10'd0, 1'b0);
        wait_drained();

        // Size one: nothing allocatable, slot 0 readable, slot 1 out of range.
        write_size(11'd1);
        add_req(MODE_ALLOC, 10'd0, 1'b0);
        add_req(MODE_READ,  10'd0, 1'b0);
        add_req(MODE_WRITE, 10'd1, 1'b1);
        wait_drained();

        // Clear extent: at size 9 the clear reaches slot 15 but not 16.
        write_size(11'd1024);
        add_req(MODE_WRITE, 10'd15, 1'b1);
        add_req(MODE_WRITE, 10'd16, 1'b1);
        wait_drained();
        write_size(11'd9);
        add_req(MODE_ALLOC, 10'd0, 1'b0);
        add_req(MODE_CLEAR, 10'd0, 1'b0);
        wait_drained();
        write_size(11'd1024);
        add_req(MODE_READ, 10'd15, 1'b0);
        add_req(MODE_READ, 10'd16, 1'b0);
        wait_drained();

        // Random phases, rotating the idle pattern; the first one also
        // carries the long receiver hold-off.
        for (int p = 0; p < 12; p++)
            random_phase(sizes[p], p % 4, PHASE_BEATS, p == 0);

        wait_drained();
        repeat (40) @(posedge clk);
        if (bad_beats == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
